>>> hdl/circular_doubly_linked_list_cursor_assert.svh
// Assertion macros for the track list block.
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_CURSOR_ASSERT_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_CURSOR_ASSERT_SVH
`ifndef SYNTHESIS
`define CDL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CDL_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDL_ASSERT(label, clk, rst_n, prop, msg)
`define CDL_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> hdl/cdll_pkg.sv
`default_nettype none
package cdll_pkg;
  localparam int Capacity = 64;
  localparam int SlotW = 6;
  localparam int CountW = 7;

  typedef enum logic [3:0] {
    CMD_INS_FRONT = 4'd0, CMD_INS_BACK = 4'd1, CMD_INS_AT = 4'd2,
    CMD_DEL_FRONT = 4'd3, CMD_DEL_BACK = 4'd4, CMD_DEL_AT = 4'd5,
    CMD_LIST_FWD = 4'd6, CMD_LIST_BWD = 4'd7, CMD_NEXT = 4'd8, CMD_PREV = 4'd9
  } cmd_e;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_RD, ST_WAIT, ST_WALK, ST_LINK1, ST_LINK2,
    ST_UNLINK, ST_LIST, ST_RESULT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture input item
    logic rd_issue;    // read node at walk pointer
    logic step;        // advance walk pointer along link
    logic step_bwd;    // step uses previous link
    logic start_head;  // walk pointer = head
    logic start_tail;  // walk pointer = prev(head), needs read data
    logic ins_empty;   // single-node insert
    logic link1;       // write new node and fix neighbor
    logic link2;       // fix second neighbor, update head, count
    logic unlink;      // remove node at walk pointer
    logic emit_list;   // load output from listed node
    logic emit_play;   // load output from cursor node, move cursor
    logic emit_stat;   // load status result
    logic cnt_dec;     // decrement remaining walk count
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic walk_done;
    logic out_busy;
    logic [3:0] cmd;
  } sts_t;
endpackage
`default_nettype wire

>>> hdl/cdll_datapath.sv
`default_nettype none
module cdll_datapath
  import cdll_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctl_t        ctl_i,
  output sts_t             sts_o,
  input  wire logic [3:0]  cmd_i,
  input  wire logic [15:0] id_i,
  input  wire logic [15:0] len_i,
  input  wire logic [6:0]  pos_i,
  input  wire logic [1:0]  stat_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       out_status_o,
  output logic [15:0]      out_id_o,
  output logic [15:0]      out_len_o,
  output logic             out_last_o
);
  logic [15:0] ids_mem [Capacity];
  logic [15:0] lens_mem [Capacity];
  logic [SlotW-1:0] nxt_mem [Capacity];
  logic [SlotW-1:0] prv_mem [Capacity];

  logic [Capacity-1:0] free_q;
  logic [SlotW-1:0] head_q, cursor_q, walk_q, new_q, nb_q;
  logic [CountW-1:0] count_q, left_q;
  logic [3:0] cmd_q;
  logic [15:0] id_q, len_q;
  logic [6:0] pos_q;
  logic [15:0] rd_id, rd_len;
  logic [SlotW-1:0] rd_nxt, rd_prv;
  logic [SlotW-1:0] free_slot;
  logic has_free;

  always_comb begin
    free_slot = '0;
    has_free = 1'b0;
    for (int s = Capacity - 1; s >= 0; s--) begin
      if (free_q[s]) begin
        free_slot = SlotW'(s);
        has_free = 1'b1;
      end
    end
  end

  // Registered reads of all four stores at the walk pointer.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_issue) begin
      rd_id <= ids_mem[walk_q];
      rd_len <= lens_mem[walk_q];
      rd_nxt <= nxt_mem[walk_q];
      rd_prv <= prv_mem[walk_q];
    end
  end

  // Writes: link1 places the new node before nb_q (pred = rd_prv of nb).
  // link2 repairs prev of nb. unlink writes next of pred and prev of succ
  // over two ports.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins_empty) begin
      ids_mem[new_q] <= id_q;
      lens_mem[new_q] <= len_q;
      nxt_mem[new_q] <= new_q;
      prv_mem[new_q] <= new_q;
    end else if (ctl_i.link1) begin
      ids_mem[new_q] <= id_q;
      lens_mem[new_q] <= len_q;
      nxt_mem[new_q] <= nb_q;
      prv_mem[new_q] <= rd_prv;
      nxt_mem[rd_prv] <= new_q;
    end else if (ctl_i.link2) begin
      prv_mem[nb_q] <= new_q;
    end else if (ctl_i.unlink) begin
      nxt_mem[rd_prv] <= rd_nxt;
      prv_mem[rd_nxt] <= rd_prv;
    end
  end

  logic [CountW-1:0] steps;
  always_comb begin
    steps = '0;
    if (cmd_i == CMD_INS_AT) begin
      // steps from the head to the node before which to insert (the successor)
      steps = (pos_i <= 7'd1) ? '0 : CountW'(pos_i - 7'd1);
      if (steps > count_q) steps = count_q;
    end else if (cmd_i == CMD_DEL_AT) begin
      steps = (pos_i <= 7'd1) ? '0 : CountW'(pos_i - 7'd1);
      if (count_q != '0 && steps > count_q - 1'b1) steps = count_q - 1'b1;
    end else if (cmd_i == CMD_LIST_FWD || cmd_i == CMD_LIST_BWD) begin
      steps = count_q;
    end
  end

  logic [1:0] o_stat;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
      head_q <= '0;
      cursor_q <= '0;
      count_q <= '0;
      out_valid_o <= 1'b0;
      walk_q <= '0;
      left_q <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (ctl_i.load) begin
        cmd_q <= cmd_i;
        id_q <= id_i;
        len_q <= len_i;
        pos_q <= pos_i;
        left_q <= steps;
        new_q <= free_slot;
        // Play commands read the cursor node, everything else starts at the head.
        walk_q <= (cmd_i == CMD_NEXT || cmd_i == CMD_PREV) ? cursor_q : head_q;
      end
      if (ctl_i.start_head) walk_q <= head_q;
      if (ctl_i.start_tail) walk_q <= rd_prv;
      if (ctl_i.step) walk_q <= ctl_i.step_bwd ? rd_prv : rd_nxt;
      if (ctl_i.cnt_dec) left_q <= left_q - 1'b1;
      if (ctl_i.rd_issue) nb_q <= walk_q;
      if (ctl_i.ins_empty) begin
        free_q[new_q] <= 1'b0;
        head_q <= new_q;
        cursor_q <= new_q;
        count_q <= count_q + 1'b1;
      end
      if (ctl_i.link2) begin
        free_q[new_q] <= 1'b0;
        count_q <= count_q + 1'b1;
        if (cmd_q == CMD_INS_FRONT || (cmd_q == CMD_INS_AT && pos_q <= 7'd1))
          head_q <= new_q;
      end
      if (ctl_i.unlink) begin
        free_q[nb_q] <= 1'b1;
        count_q <= count_q - 1'b1;
        if (count_q <= 7'd1) begin
          head_q <= '0;
          cursor_q <= '0;
        end else begin
          if (head_q == nb_q) head_q <= rd_nxt;
          if (cursor_q == nb_q) cursor_q <= rd_nxt;
        end
      end
      if (ctl_i.emit_list || ctl_i.emit_play || ctl_i.emit_stat) out_valid_o <= 1'b1;
      if (ctl_i.emit_play)
        cursor_q <= (cmd_q == CMD_NEXT) ? rd_nxt : rd_prv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_list || ctl_i.emit_play) begin
      out_status_o <= STAT_OK;
      out_id_o <= rd_id;
      out_len_o <= rd_len;
      out_last_o <= ctl_i.emit_play || (left_q == 7'd1);
    end else if (ctl_i.emit_stat) begin
      out_status_o <= stat_i;
      out_id_o <= '0;
      out_len_o <= '0;
      out_last_o <= 1'b1;
    end
  end

  assign o_stat = '0;
  assign sts_o.empty = (count_q == '0);
  assign sts_o.full = (count_q >= CountW'(Capacity)) || !has_free || (o_stat != '0);
  assign sts_o.walk_done = (left_q == '0);
  assign sts_o.out_busy = out_valid_o;
  assign sts_o.cmd = cmd_q;
endmodule
`default_nettype wire

>>> hdl/cdll_ctrl.sv
`default_nettype none
module cdll_ctrl
  import cdll_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [3:0] in_cmd_i,
  output logic            in_ready_o,
  input  wire sts_t       sts_i,
  output ctl_t            ctl_o,
  output logic [1:0]      stat_o
);
  state_e state_q, state_d;
  logic after_q, after_d;  // walk pass finished, next read is the target

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      after_q <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
    end
  end

  always_comb begin
    state_d = state_q;
    after_d = after_q;
    ctl_o = '0;
    stat_o = STAT_OK;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !sts_i.out_busy;
        if (in_valid_i && in_ready_o && in_cmd_i <= CMD_PREV) begin
          ctl_o.load = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        after_d = 1'b0;
        if (sts_i.cmd <= CMD_INS_AT) begin
          if (sts_i.full) begin
            stat_o = STAT_FULL;
            ctl_o.emit_stat = 1'b1;
            state_d = ST_IDLE;
          end else if (sts_i.empty) begin
            ctl_o.ins_empty = 1'b1;
            ctl_o.emit_stat = 1'b1;
            state_d = ST_IDLE;
          end else begin
            ctl_o.rd_issue = 1'b1;
            state_d = ST_WAIT;
          end
        end else if (sts_i.empty) begin
          stat_o = STAT_EMPTY;
          ctl_o.emit_stat = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ctl_o.rd_issue = 1'b1;
          state_d = ST_WAIT;
        end
      end
      // Data of node at nb is valid here.
      ST_WAIT: begin
        case (sts_i.cmd)
          CMD_INS_FRONT, CMD_INS_BACK: state_d = ST_LINK1;
          CMD_INS_AT: begin
            if (sts_i.walk_done) state_d = ST_LINK1;
            else begin
              ctl_o.step = 1'b1;
              ctl_o.cnt_dec = 1'b1;
              state_d = ST_RD;
            end
          end
          CMD_DEL_FRONT: state_d = ST_UNLINK;
          CMD_DEL_AT: begin
            if (sts_i.walk_done) state_d = ST_UNLINK;
            else begin
              ctl_o.step = 1'b1;
              ctl_o.cnt_dec = 1'b1;
              state_d = ST_RD;
            end
          end
          CMD_DEL_BACK, CMD_LIST_BWD: begin
            if (!after_q) begin
              ctl_o.start_tail = 1'b1;
              after_d = 1'b1;
              state_d = ST_RD;
            end else if (sts_i.cmd == CMD_DEL_BACK) state_d = ST_UNLINK;
            else state_d = ST_LIST;
          end
          CMD_LIST_FWD: state_d = ST_LIST;
          CMD_NEXT, CMD_PREV: begin
            if (!after_q) begin
              after_d = 1'b1;
              state_d = ST_WALK;
            end else if (!sts_i.out_busy) begin
              ctl_o.emit_play = 1'b1;
              state_d = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_RD: begin
        ctl_o.rd_issue = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WALK: begin
        state_d = ST_WAIT;
      end
      ST_LINK1: begin
        ctl_o.link1 = 1'b1;
        state_d = ST_LINK2;
      end
      ST_LINK2: begin
        ctl_o.link2 = 1'b1;
        ctl_o.emit_stat = 1'b1;
        state_d = ST_IDLE;
      end
      ST_UNLINK: begin
        ctl_o.unlink = 1'b1;
        ctl_o.emit_stat = 1'b1;
        state_d = ST_IDLE;
      end
      ST_LIST: begin
        if (!sts_i.out_busy) begin
          ctl_o.emit_list = 1'b1;
          ctl_o.cnt_dec = 1'b1;
          if (sts_i.walk_done) state_d = ST_IDLE;
          else begin
            ctl_o.step = 1'b1;
            ctl_o.step_bwd = (sts_i.cmd == CMD_LIST_BWD);
            state_d = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (sts_i.walk_done) state_d = ST_IDLE;
        else begin
          ctl_o.rd_issue = 1'b1;
          state_d = ST_WAIT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/circular_doubly_linked_list_cursor.sv
// Sequencing: a status-only result comes from decode; an insert or delete at an end or a play
// command first reads its node; positional commands also step and read once per node walked.
// Listings read each node and emit it once the output is free; backward ones first read the tail.
// Throughput: one item at a time; the next item is taken once the final result has left.
// Reset: asynchronous, active low; the list is emptied, every slot freed, head and
// cursor cleared. Node memories are not cleared.
`default_nettype none
`include "circular_doubly_linked_list_cursor_assert.svh"
module circular_doubly_linked_list_cursor
  import cdll_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: command[3:0], track_id[19:4], track_length[35:20], position[42:36]
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: status[1:0], out_id[17:2], out_length[33:18]
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast
);
  ctl_t ctl;
  sts_t sts;
  logic [1:0] stat;
  logic [1:0] o_status;
  logic [15:0] o_id, o_len;
  logic out_stall;

  // The controller sequences every command; the datapath holds the pool,
  // the links, head, cursor and the output register.
  cdll_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_cmd_i(s_axis_tdata[3:0]),
    .in_ready_o(s_axis_tready),
    .sts_i(sts),
    .ctl_o(ctl),
    .stat_o(stat)
  );

  cdll_datapath u_dp (
    .clk_i, .rst_ni,
    .ctl_i(ctl),
    .sts_o(sts),
    .cmd_i(s_axis_tdata[3:0]),
    .id_i(s_axis_tdata[19:4]),
    .len_i(s_axis_tdata[35:20]),
    .pos_i(s_axis_tdata[42:36]),
    .stat_i(stat),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_status_o(o_status),
    .out_id_o(o_id),
    .out_len_o(o_len),
    .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, o_len, o_id, o_status};
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  `CDL_ASSERT(a_rdy_idle, clk_i, rst_ni, s_axis_tready |-> !m_axis_tvalid, "ready while output pending")
  `CDL_ASSERT(a_hold, clk_i, rst_ni, out_stall |=> $stable(m_axis_tdata), "output changed under stall")
endmodule
`default_nettype wire
